[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked condition check with async reset disable
`define ASSERT_IMP(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// next-cycle implication with async reset disable
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/sspm_pkg.sv]
// shared types, constants and command text tables for the poll master
`timescale 1ns / 1ps
package sspm_pkg;
  localparam int unsigned PollCommandsDef = 15;
  localparam int unsigned ValueDigitsDef  = 3;
  localparam logic [7:0] EscByte    = 8'd27;
  localparam logic [7:0] EndByte    = 8'd38;
  localparam logic [7:0] CmdCooloff = 8'd252;
  localparam logic [7:0] CmdPower   = 8'd253;
  localparam logic [7:0] CmdTemp    = 8'd254;
  localparam logic [7:0] CmdDone    = 8'd255;
  localparam logic [11:0] PhaseCool1 = 12'd2049;
  localparam logic [11:0] PhaseCool2 = 12'd2050;
  localparam logic [7:0] TempCheckAdd = 8'd75;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpRx    = 2'd1;
  localparam logic [1:0] OpPower = 2'd2;
  localparam logic [1:0] OpTemp  = 2'd3;

  localparam logic [2:0] KindTx    = 3'd0;
  localparam logic [2:0] KindRep   = 3'd1;
  localparam logic [2:0] KindErr   = 3'd2;
  localparam logic [2:0] KindPower = 3'd3;
  localparam logic [2:0] KindTemp  = 3'd4;

  localparam logic [1:0] RegReply   = 2'd0;
  localparam logic [1:0] RegRetry   = 2'd1;
  localparam logic [1:0] RegStartup = 2'd2;

  // one job handed from front to back: a burst of words
  typedef struct packed {
    logic        err;       // comm error word first
    logic        send;      // esc plus command line
    logic [3:0]  line_len;  // 0 or 9 characters
    logic [71:0] line;      // character 0 in the top byte
    logic        single;    // one report / setpoint word
    logic [2:0]  kind;
    logic [3:0]  index;
    logic [11:0] value;
    logic [12:0] power;
    logic        cool;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

  function automatic logic [71:0] poll_line(input logic [3:0] n);
    case (n)
      4'd1:    poll_line = "RD100057&";
      4'd2:    poll_line = "RC60005B&";
      4'd3:    poll_line = "RC50005A&";
      4'd4:    poll_line = "RD000056&";
      4'd5:    poll_line = "RD200058&";
      4'd6:    poll_line = "RD300059&";
      4'd7:    poll_line = "RD40005A&";
      4'd8:    poll_line = "RDF0006C&";
      4'd9:    poll_line = "RDD0006A&";
      4'd10:   poll_line = "RDE0006B&";
      4'd11:   poll_line = "RDA00067&";
      4'd12:   poll_line = "REF0006D&";
      4'd13:   poll_line = "RD80005E&";
      4'd14:   poll_line = "RC000055&";
      4'd15:   poll_line = "RDB00068&";
      default: poll_line = "RD90005F&";
    endcase
  endfunction
endpackage

[rtl/stove_serial_poll_master.sv]
// top level of the stove serial poll master
`timescale 1ns / 1ps
// Poll master for a heating appliance on a serial link.
// Input channel (in_valid_i / in_stall_o): one word per tick, received byte
// or setpoint request, selected by opcode_i.
// Output channel (out_valid_o / out_stall_i): result words; last_o marks the
// final word caused by one input word.
// The front part updates the timer, parser and command state in the cycle a
// word is accepted and queues at most one job; a two-entry queue decouples it
// from the back part, which emits one word per cycle from the job while the
// output does not stall. With the back part idle, a job passes the queue
// and then the output register before its first result word is offered.
// Throughput: a timer expiry yields up to 11 words; other inputs yield at
// most one word. The back part's one-word-per-cycle serializer sets the rate
// while the output does not stall; a tick without expiry or a partial reply
// byte yields no result.
// Stalls: output stalls back up into the queue; the input stalls only when
// the queue is full.
// Reset: gap timer loads 1000 ticks, no command sent yet, power unknown.
// Configuration via APB: 0 reply gap, 4 retry gap, 8 startup gap (also
// reloads the timer). Write only while idle.
module stove_serial_poll_master #(
  parameter int unsigned PollCommands = sspm_pkg::PollCommandsDef,
  parameter int unsigned ValueDigits  = sspm_pkg::ValueDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  setpoint_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [3:0]  report_index_o,
  output logic [11:0] report_value_o,
  output logic [12:0] power_estimate_o,
  output logic        in_cooldown_o,
  output logic        last_o
);
  import sspm_pkg::*;

  logic [12:0] reply_q, retry_q, startup_q;
  logic        wr, st_load;
  logic [1:0]  ridx;
  logic        jv, jfull, jempty, jpop;
  job_t        job_in, job_head;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];
  assign wr = psel && penable && pwrite;
  assign st_load = wr && ridx == RegStartup;

  always_comb begin
    case (ridx)
      RegReply:   prdata = {19'd0, reply_q};
      RegRetry:   prdata = {19'd0, retry_q};
      RegStartup: prdata = {19'd0, startup_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_q <= 13'd500; retry_q <= 13'd5000; startup_q <= 13'd1000;
    end else if (wr) begin
      case (ridx)
        RegReply:   reply_q <= pwdata[12:0];
        RegRetry:   retry_q <= pwdata[12:0];
        RegStartup: startup_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  sspm_front #(.PollCommands(PollCommands), .ValueDigits(ValueDigits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .rx_byte_i,
    .setpoint_value_i, .reply_gap_i(reply_q), .retry_gap_i(retry_q),
    .startup_load_i(st_load), .startup_val_i(pwdata[12:0]),
    .job_valid_o(jv), .job_full_i(jfull), .job_o(job_in)
  );

  sspm_queue u_queue (
    .clk_i, .rst_ni, .push_i(jv), .push_job_i(job_in), .full_o(jfull),
    .pop_i(jpop), .empty_o(jempty), .head_o(job_head)
  );

  sspm_back u_back (
    .clk_i, .rst_ni, .empty_i(jempty), .job_i(job_head), .pop_o(jpop),
    .out_valid_o, .out_stall_i, .kind_o, .tx_byte_o, .report_index_o,
    .report_value_o, .power_estimate_o, .in_cooldown_o, .last_o
  );
endmodule

[rtl/sspm_front.sv]
// front part: timer, parser and command selection, at most one job per accepted word
`timescale 1ns / 1ps
module sspm_front #(
  parameter int unsigned PollCommands = sspm_pkg::PollCommandsDef,
  parameter int unsigned ValueDigits  = sspm_pkg::ValueDigitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        setpoint_value_i,
  input  logic [12:0]       reply_gap_i,
  input  logic [12:0]       retry_gap_i,
  input  logic              startup_load_i,
  input  logic [12:0]       startup_val_i,
  output logic              job_valid_o,
  input  logic              job_full_i,
  output sspm_pkg::job_t    job_o
);
  import sspm_pkg::*;

  logic [7:0]  cmd_q, cmd_d;
  logic        cool_q, cool_d, coolb_q, coolb_d;
  logic        ppend_q, ppend_d, tpend_q, tpend_d;
  logic [2:0]  plev_q, plev_d;
  logic [4:0]  tlev_q, tlev_d;
  logic [12:0] cur_q, cur_d;
  logic [2:0]  pos_q, pos_d;
  logic [11:0] acc_q, acc_d;
  logic        stop_q, stop_d;
  logic [12:0] gap_q, gap_d;
  logic        seen_q, seen_d;

  logic        acc_en;
  logic [4:0]  hv;
  logic [7:0]  nxt, chk;
  logic        poll_n;
  job_t        job;
  logic        emit;

  assign in_stall_o = job_full_i;
  assign acc_en = in_valid_i && !job_full_i;

  always_comb begin
    hv = 5'h10;
    if (rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39) hv = {1'b0, rx_byte_i[3:0]};
    else if ((rx_byte_i >= 8'h41 && rx_byte_i <= 8'h46) ||
             (rx_byte_i >= 8'h61 && rx_byte_i <= 8'h66))
      hv = {1'b0, rx_byte_i[3:0] + 4'd9};
  end

  always_comb begin
    cmd_d = cmd_q; cool_d = cool_q; coolb_d = coolb_q;
    ppend_d = ppend_q; tpend_d = tpend_q; plev_d = plev_q; tlev_d = tlev_q;
    cur_d = cur_q; pos_d = pos_q; acc_d = acc_q; stop_d = stop_q;
    gap_d = gap_q; seen_d = seen_q;
    job = '0; emit = 1'b0; nxt = '0; chk = '0; poll_n = 1'b0;
    case (opcode_i)
      OpTick: begin
        if (gap_q != '0) begin
          gap_d = gap_q - 13'd1;
        end else begin
          emit = 1'b1;
          job.err = !seen_q;
          seen_d = 1'b0;
          gap_d = retry_gap_i;
          job.send = 1'b1;
          job.line_len = 4'd9;
          nxt = cmd_q + 8'd1;
          if (cool_q) begin
            ppend_d = 1'b0;
            if (!coolb_q) nxt = CmdCooloff;
          end else if (ppend_q) nxt = CmdPower;
          else if (tpend_q) nxt = CmdTemp;
          coolb_d = cool_q;
          cmd_d = nxt;
          if (nxt >= 8'd1 && nxt <= 8'(PollCommands)) begin
            job.line = poll_line(nxt[3:0]);
          end else if (nxt == CmdCooloff) begin
            job.line = "RF000058&";
          end else if (nxt == CmdPower) begin
            chk = 8'h58 + {5'd0, plev_q};
            job.line = {"RF00", hex_char({1'b0, plev_q}), "0",
                        hex_char(chk[7:4]), hex_char(chk[3:0]), "&"};
            if (!(ppend_q && !cool_q)) job.line_len = 4'd0;
            ppend_d = 1'b0;
            cmd_d = CmdDone;
          end else if (nxt == CmdTemp) begin
            chk = {3'd0, tlev_q} + TempCheckAdd;
            job.line = {"RF2", hex_char({3'd0, tlev_q[4]}), hex_char(tlev_q[3:0]), "0",
                        hex_char(chk[7:4]), hex_char(chk[3:0]), "&"};
            if (!tpend_q) job.line_len = 4'd0;
            tpend_d = 1'b0;
            cmd_d = CmdDone;
          end else begin
            cmd_d = '0;
            job.line = poll_line(4'd0);
          end
        end
      end
      OpRx: begin
        if (rx_byte_i != EndByte) begin
          if (pos_q >= 3'd2 && 32'(pos_q) < 2 + ValueDigits && !stop_q) begin
            if (hv[4]) stop_d = 1'b1;
            else acc_d = {acc_q[7:0], hv[3:0]};
          end
          if (pos_q < 3'd7) pos_d = pos_q + 3'd1;
        end else begin
          pos_d = '0; acc_d = '0; stop_d = 1'b0;
          gap_d = reply_gap_i; seen_d = 1'b1;
          poll_n = (cmd_q >= 8'd1 && cmd_q <= 8'(PollCommands));
          if (cmd_q == 8'd0) begin
            cool_d = 1'b0;
            if (acc_q == '0 || acc_q == PhaseCool2) cur_d = '0;
            else if (acc_q == PhaseCool1) begin
              cur_d = '0; cool_d = 1'b1;
            end
          end else if (cmd_q == 8'd6) begin
            cur_d = {1'b0, acc_q};
          end else if (cmd_q == 8'd7 && acc_q != '0 &&
                       $signed(cur_q) > $signed({1'b0, acc_q})) begin
            cur_d = {1'b0, acc_q};
          end
          if (cmd_q == 8'd0 || poll_n) begin
            emit = 1'b1; job.single = 1'b1; job.kind = KindRep;
            job.index = cmd_q[3:0]; job.value = acc_q;
          end
        end
      end
      OpPower: begin
        if (setpoint_value_i <= 8'd5) begin
          emit = 1'b1; job.single = 1'b1; job.kind = KindPower;
          if (!cool_q) begin
            ppend_d = 1'b1; plev_d = setpoint_value_i[2:0];
            job.value = {4'd0, setpoint_value_i};
          end
        end
      end
      default: begin
        if (setpoint_value_i >= 8'd16 && setpoint_value_i <= 8'd25) begin
          emit = 1'b1; job.single = 1'b1; job.kind = KindTemp;
          tpend_d = 1'b1; tlev_d = setpoint_value_i[4:0];
          job.value = {4'd0, setpoint_value_i};
        end
      end
    endcase
    job.power = cur_d;
    job.cool  = cool_d;
    if (startup_load_i) gap_d = startup_val_i;
  end

  assign job_valid_o = acc_en && emit;
  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0; cool_q <= 1'b0; coolb_q <= 1'b0;
      ppend_q <= 1'b0; tpend_q <= 1'b0; plev_q <= '0; tlev_q <= '0;
      cur_q <= '1; pos_q <= '0; acc_q <= '0; stop_q <= 1'b0;
      gap_q <= 13'd1000; seen_q <= 1'b1;
    end else if (acc_en) begin
      cmd_q <= cmd_d; cool_q <= cool_d; coolb_q <= coolb_d;
      ppend_q <= ppend_d; tpend_q <= tpend_d; plev_q <= plev_d; tlev_q <= tlev_d;
      cur_q <= cur_d; pos_q <= pos_d; acc_q <= acc_d; stop_q <= stop_d;
      gap_q <= gap_d; seen_q <= seen_d;
    end else if (startup_load_i) begin
      gap_q <= startup_val_i;
    end
  end
endmodule

[rtl/sspm_queue.sv]
// two-entry job queue between front and back
`timescale 1ns / 1ps
module sspm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sspm_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sspm_pkg::job_t head_o
);
  import sspm_pkg::*;
  `include "assert_macros.svh"

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

  `ASSERT_IMP(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `ASSERT_IMP(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")
  `ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, !(pop_i && empty_o), "pop from empty queue")
endmodule

[rtl/sspm_back.sv]
// back part: serializes one job into output words behind an output register
`timescale 1ns / 1ps
module sspm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  sspm_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     kind_o,
  output logic [7:0]     tx_byte_o,
  output logic [3:0]     report_index_o,
  output logic [11:0]    report_value_o,
  output logic [12:0]    power_estimate_o,
  output logic           in_cooldown_o,
  output logic           last_o
);
  import sspm_pkg::*;
  `include "assert_macros.svh"

  // step 0 error, 1 esc, 2..10 line characters, 11 single word, F idle
  logic [3:0] step_q, step_d, first, nstep;
  logic       vld_q, load, fin;
  logic [2:0] k; logic [7:0] tx; logic [3:0] ix; logic [11:0] vl; logic ls;
  logic [71:0] sh;
  logic [3:0] cur;

  always_comb begin
    first = job_i.single ? 4'd11 : (job_i.err ? 4'd0 : 4'd1);
  end
  // current step: idle means a fresh job starts at its first step
  assign cur = (step_q == 4'hF) ? first : step_q;
  assign sh  = job_i.line << ({3'd0, cur - 4'd2} * 7'd8);

  always_comb begin
    k = KindTx; tx = '0; ix = '0; vl = '0; nstep = cur + 4'd1; ls = 1'b0;
    case (cur)
      4'd0: begin k = KindErr; end
      4'd1: begin
        tx = EscByte;
        ls = job_i.line_len == 4'd0;
      end
      4'd11: begin k = job_i.kind; ix = job_i.index; vl = job_i.value; ls = 1'b1; end
      default: begin tx = sh[71:64]; ls = cur == 4'd10; end
    endcase
  end

  assign load = !empty_i && (!vld_q || !out_stall_i);
  assign fin  = load && ls;
  assign pop_o = fin;

  always_comb begin
    step_d = step_q;
    if (fin) step_d = 4'hF;
    else if (load) step_d = nstep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; step_q <= 4'hF;
    end else begin
      if (load) vld_q <= 1'b1;
      else if (!out_stall_i) vld_q <= 1'b0;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o <= k; tx_byte_o <= tx; report_index_o <= ix; report_value_o <= vl;
      power_estimate_o <= job_i.power; in_cooldown_o <= job_i.cool; last_o <= ls;
    end
  end

  assign out_valid_o = vld_q;

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(kind_o), "word changed")
  `ASSERT_NEXT(a_hold_vld, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "word dropped")
  `ASSERT_NEXT(a_pop_last, clk_i, rst_ni, pop_o, out_valid_o && last_o, "job without last word")
endmodule
